### hdl/link_session_supervisor_defines.svh
// Assertion macros shared by the link session supervisor files.
`ifndef LINK_SESSION_SUPERVISOR_DEFINES_SVH
`define LINK_SESSION_SUPERVISOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the next cycle.
`define LSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/lss_pkg.sv
// Package with types and constants of the link session supervisor.
`timescale 1ns / 1ps
`default_nettype none
package lss_pkg;
  localparam int unsigned ReplayDepth = 8;
  localparam int unsigned ReplayIdxW = (ReplayDepth > 1) ? $clog2(ReplayDepth) : 1;
  localparam logic [31:0] SeqHalfRange = 32'h8000_0000;

  typedef enum logic [2:0] {
    ACT_HELLO = 3'd0, ACT_HEARTBEAT = 3'd1, ACT_CONTROL = 3'd2, ACT_STOP = 3'd3,
    ACT_CLEAR = 3'd4, ACT_PING = 3'd5, ACT_TICK = 3'd6, ACT_NONE = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    LINK_WAIT = 2'd0, LINK_UP = 2'd1, LINK_LOST = 2'd2
  } link_e;

  localparam logic [2:0] RkNone = 3'd0;
  localparam logic [2:0] RkHelloAck = 3'd1;
  localparam logic [2:0] RkStatus = 3'd2;
  localparam logic [2:0] RkPong = 3'd3;
  localparam logic [2:0] RkAck = 3'd4;
  localparam logic [2:0] RkNack = 3'd5;

  localparam logic [2:0] CodeOk = 3'd0;
  localparam logic [2:0] HelloRole = 3'd1;
  localparam logic [2:0] HelloVersion = 3'd2;
  localparam logic [2:0] HelloPayload = 3'd3;
  localparam logic [2:0] HelloCaps = 3'd4;
  localparam logic [2:0] NackNotReady = 3'd1;
  localparam logic [2:0] NackStale = 3'd2;
  localparam logic [2:0] NackConflict = 3'd3;
  localparam logic [2:0] NackClearDenied = 3'd4;

  localparam logic [2:0] CfgLinkTimeout = 3'd0;
  localparam logic [2:0] CfgCtrlTimeout = 3'd1;
  localparam logic [2:0] CfgLocalVersion = 3'd2;
  localparam logic [2:0] CfgPeerRole = 3'd3;
  localparam logic [2:0] CfgMinPayload = 3'd4;
  localparam logic [2:0] CfgReqCaps = 3'd5;
  localparam logic [2:0] CfgMaxAge = 3'd6;
  localparam logic [2:0] CfgTargetCode = 3'd7;

  typedef struct packed {
    logic [15:0] link_timeout;
    logic [15:0] ctrl_timeout;
    logic [7:0]  local_version;
    logic [7:0]  peer_role;
    logic [15:0] min_payload;
    logic [31:0] req_caps;
    logic [15:0] max_age;
    logic [7:0]  target_code;
  } cfg_t;

  // One classified message as it travels from the front to the back.
  typedef struct packed {
    action_e     action;
    logic [2:0]  hello_code;
    logic        ctrl_fields_ok;
    logic [31:0] sender;
    logic [31:0] seq;
    logic [31:0] req_id;
    logic [15:0] crc;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  reply_kind;
    logic [2:0]  reply_code;
    logic [31:0] echo_sequence;
    logic [31:0] echo_id;
    link_e       session_state;
    logic        remote_stop;
    logic        ctrl_valid;
    logic [31:0] last_ctrl_seq;
    logic [31:0] gap_total;
    logic [31:0] mbox_gen;
    logic        mbox_valid;
    logic [31:0] mbox_overwrites;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCAN, BK_EXEC, BK_OUT
  } back_state_e;
endpackage
`default_nettype wire

### hdl/link_session_supervisor.sv
// Top level of the link session supervisor: configuration registers and the two parts.
// One result per item. An item passes the back part's idle, execute and output
// states, with a scan state before execute for a stop or clear request, whose
// replay cache is walked one entry per cycle; a two-entry queue parts the front
// from the back, and a one-entry output register holds the result until it is popped.
`timescale 1ns / 1ps
`default_nettype none
module link_session_supervisor import lss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  action_i,
  input  wire logic [31:0] sender_boot_id_i,
  input  wire logic [31:0] wire_sequence_i,
  input  wire logic [7:0]  kind_code_i,
  input  wire logic [7:0]  version_low_i,
  input  wire logic [7:0]  version_high_i,
  input  wire logic [15:0] peer_max_payload_i,
  input  wire logic [31:0] capability_bits_i,
  input  wire logic [7:0]  control_flags_i,
  input  wire logic [15:0] capture_age_i,
  input  wire logic [31:0] request_id_i,
  input  wire logic [15:0] payload_crc_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       reply_kind_o,
  output logic [2:0]       reply_code_o,
  output logic [31:0]      echo_sequence_o,
  output logic [31:0]      echo_id_o,
  output logic [1:0]       session_state_o,
  output logic             remote_stop_o,
  output logic             ctrl_valid_o,
  output logic [31:0]      last_control_sequence_o,
  output logic [31:0]      gap_total_o,
  output logic [31:0]      mailbox_generation_o,
  output logic             mailbox_valid_o,
  output logic [31:0]      mailbox_overwrites_o
);
  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid, cmd_take;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link_timeout <= 16'd500;
      cfg_q.ctrl_timeout <= 16'd200;
      cfg_q.local_version <= 8'd1;
      cfg_q.peer_role <= 8'd1;
      cfg_q.min_payload <= 16'd52;
      cfg_q.req_caps <= 32'd0;
      cfg_q.max_age <= 16'd1000;
      cfg_q.target_code <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLinkTimeout:  cfg_q.link_timeout <= cfg_data_i[15:0];
        CfgCtrlTimeout:  cfg_q.ctrl_timeout <= cfg_data_i[15:0];
        CfgLocalVersion: cfg_q.local_version <= cfg_data_i[7:0];
        CfgPeerRole:     cfg_q.peer_role <= cfg_data_i[7:0];
        CfgMinPayload:   cfg_q.min_payload <= cfg_data_i[15:0];
        CfgReqCaps:      cfg_q.req_caps <= cfg_data_i;
        CfgMaxAge:       cfg_q.max_age <= cfg_data_i[15:0];
        CfgTargetCode:   cfg_q.target_code <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  lss_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .push_i(push), .full_o(full),
    .action_i, .sender_boot_id_i, .wire_sequence_i, .kind_code_i, .version_low_i,
    .version_high_i, .peer_max_payload_i, .capability_bits_i, .control_flags_i,
    .capture_age_i, .request_id_i, .payload_crc_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  lss_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_take_o(cmd_take), .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign reply_kind_o = res.reply_kind;
  assign reply_code_o = res.reply_code;
  assign echo_sequence_o = res.echo_sequence;
  assign echo_id_o = res.echo_id;
  assign session_state_o = res.session_state;
  assign remote_stop_o = res.remote_stop;
  assign ctrl_valid_o = res.ctrl_valid;
  assign last_control_sequence_o = res.last_ctrl_seq;
  assign gap_total_o = res.gap_total;
  assign mailbox_generation_o = res.mbox_gen;
  assign mailbox_valid_o = res.mbox_valid;
  assign mailbox_overwrites_o = res.mbox_overwrites;
endmodule
`default_nettype wire

### hdl/lss_front.sv
// Front part: checks hello and control fields and queues classified messages.
`timescale 1ns / 1ps
`default_nettype none
`include "link_session_supervisor_defines.svh"
module lss_front import lss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [31:0] sender_boot_id_i,
  input  wire logic [31:0] wire_sequence_i,
  input  wire logic [7:0]  kind_code_i,
  input  wire logic [7:0]  version_low_i,
  input  wire logic [7:0]  version_high_i,
  input  wire logic [15:0] peer_max_payload_i,
  input  wire logic [31:0] capability_bits_i,
  input  wire logic [7:0]  control_flags_i,
  input  wire logic [15:0] capture_age_i,
  input  wire logic [31:0] request_id_i,
  input  wire logic [15:0] payload_crc_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  wire logic        cmd_take_i
);
  cmd_t cmd;
  cmd_t fifo_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  always_comb begin
    cmd.action = action_e'(action_i);
    if (kind_code_i != cfg_i.peer_role) begin
      cmd.hello_code = HelloRole;
    end else if (version_low_i > cfg_i.local_version ||
                 version_high_i < cfg_i.local_version) begin
      cmd.hello_code = HelloVersion;
    end else if (peer_max_payload_i < cfg_i.min_payload) begin
      cmd.hello_code = HelloPayload;
    end else if ((capability_bits_i & cfg_i.req_caps) != cfg_i.req_caps) begin
      cmd.hello_code = HelloCaps;
    end else begin
      cmd.hello_code = CodeOk;
    end
    cmd.ctrl_fields_ok = (kind_code_i == cfg_i.target_code) && control_flags_i[0] &&
                         (capture_age_i <= cfg_i.max_age);
    cmd.sender = sender_boot_id_i;
    cmd.seq = wire_sequence_i;
    cmd.req_id = request_id_i;
    cmd.crc = payload_crc_i;
  end

  assign full_o = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rd_q];

  wire logic do_push = push_i && !full_o;
  wire logic do_pop = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `LSS_ASSERT_NEXT(a_fifo_cnt, do_push && !do_pop, cnt_q != 2'd0)
  `LSS_ASSERT_IMP(a_fifo_bound, 1'b1, cnt_q <= 2'd2)
  `LSS_ASSERT_NEXT(a_fifo_pop, do_pop && !do_push && cnt_q == 2'd1, !cmd_valid_o)
endmodule
`default_nettype wire

### hdl/lss_back.sv
// Back part: session state, watchdogs, replay cache walk and result queue.
`timescale 1ns / 1ps
`default_nettype none
`include "link_session_supervisor_defines.svh"
module lss_back import lss_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  cmd_valid_i,
  input  wire cmd_t  cmd_i,
  output logic       cmd_take_o,
  output logic       empty_o,
  input  wire logic  pop_i,
  output result_t    res_o
);
  back_state_e st_q, st_d;
  cmd_t cmd_q;

  link_e link_q;
  logic peer_q, seqk_q, stop_q, ctrl_q, mbok_q, ldog_q, cdog_q;
  logic [31:0] peer_id_q, last_rx_q, last_ctrl_q, gap_q, gen_q, ovw_q;
  logic [31:0] now_q, lmark_q, cmark_q;

  // Replay cache: flip-flop valid bits, payload in plain registers read one per cycle.
  logic [ReplayDepth-1:0] used_q;
  logic        e_kind_q [ReplayDepth];
  logic [31:0] e_id_q [ReplayDepth];
  logic [15:0] e_crc_q [ReplayDepth];
  logic        e_ack_q [ReplayDepth];
  logic [2:0]  e_code_q [ReplayDepth];
  logic [ReplayIdxW-1:0] next_q, scan_q;
  logic hit_q, hit_dup_q, hit_ack_q;
  logic [2:0] hit_code_q;

  result_t out_q;
  logic full_q;

  // Output register, one entry.
  assign empty_o = !full_q;
  assign res_o = out_q;
  assign cmd_take_o = (st_q == BK_IDLE) && cmd_valid_i;

  wire logic kind_bit = (cmd_q.action == ACT_CLEAR);
  wire logic entry_match = used_q[scan_q] && (e_kind_q[scan_q] == kind_bit) &&
                           (e_id_q[scan_q] == cmd_q.req_id);
  wire logic is_cache_cmd = (cmd_i.action == ACT_STOP) || (cmd_i.action == ACT_CLEAR);
  wire logic last_scan = (32'(scan_q) == ReplayDepth - 1);

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: if (cmd_valid_i) st_d = is_cache_cmd ? BK_SCAN : BK_EXEC;
      BK_SCAN: if (last_scan) st_d = BK_EXEC;
      BK_EXEC: st_d = BK_OUT;
      BK_OUT:  if (!full_q || pop_i) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cmd_q <= cmd_i;
  end

  // Work variables for one executed message.
  link_e n_link;
  logic n_peer, n_seqk, n_stop, n_ctrl, n_mbok, n_ldog, n_cdog, n_clear, n_rec, n_ack;
  logic [31:0] n_peer_id, n_last_rx, n_last_ctrl, n_gap, n_gen, n_ovw, n_now, n_lmark, n_cmark;
  logic [2:0] r_kind, r_code;
  logic [31:0] r_seq, r_id, diff;
  logic rdy, seq_new;

  always_comb begin
    n_link = link_q; n_peer = peer_q; n_seqk = seqk_q; n_stop = stop_q;
    n_ctrl = ctrl_q; n_mbok = mbok_q; n_ldog = ldog_q; n_cdog = cdog_q;
    n_peer_id = peer_id_q; n_last_rx = last_rx_q; n_last_ctrl = last_ctrl_q;
    n_gap = gap_q; n_gen = gen_q; n_ovw = ovw_q; n_now = now_q;
    n_lmark = lmark_q; n_cmark = cmark_q;
    n_clear = 1'b0; n_rec = 1'b0; n_ack = 1'b0;
    r_kind = RkNone; r_code = CodeOk; r_seq = '0; r_id = '0;
    rdy = 1'b0; seq_new = 1'b0;
    diff = cmd_q.seq - last_rx_q;

    // Shared peer check and serial-number tracking for session messages.
    if (cmd_q.action == ACT_HEARTBEAT || cmd_q.action == ACT_PING ||
        cmd_q.action == ACT_CONTROL || cmd_q.action == ACT_STOP ||
        cmd_q.action == ACT_CLEAR) begin
      if (link_q == LINK_UP) begin
        if (peer_q && peer_id_q == cmd_q.sender) begin
          rdy = 1'b1;
        end else begin
          n_link = LINK_WAIT; n_peer = 1'b0; n_seqk = 1'b0; n_ctrl = 1'b0;
          n_mbok = 1'b0; n_ldog = 1'b0; n_cdog = 1'b0;
        end
      end
      if (rdy) begin
        if (!seqk_q) begin
          n_seqk = 1'b1; n_last_rx = cmd_q.seq; seq_new = 1'b1;
        end else if (diff != 32'd0 && diff < SeqHalfRange) begin
          n_gap = gap_q + diff - 32'd1; n_last_rx = cmd_q.seq; seq_new = 1'b1;
        end
        if (seq_new) begin
          n_ldog = 1'b1; n_lmark = now_q;
        end
      end
    end

    case (cmd_q.action)
      ACT_HELLO: begin
        r_kind = RkHelloAck; r_code = cmd_q.hello_code; r_seq = cmd_q.seq;
        n_mbok = 1'b0; n_cdog = 1'b0; n_ctrl = 1'b0;
        if (cmd_q.hello_code == CodeOk) begin
          n_peer = 1'b1; n_peer_id = cmd_q.sender; n_seqk = 1'b1;
          n_last_rx = cmd_q.seq; n_link = LINK_UP; n_clear = 1'b1;
          n_ldog = 1'b1; n_lmark = now_q;
        end else begin
          n_link = LINK_WAIT; n_peer = 1'b0; n_seqk = 1'b0; n_ldog = 1'b0;
        end
      end
      ACT_HEARTBEAT: if (rdy && seq_new) r_kind = RkStatus;
      ACT_PING: begin
        if (rdy && seq_new) begin
          r_kind = RkPong; r_seq = cmd_q.seq; r_id = cmd_q.req_id;
        end
      end
      ACT_CONTROL: begin
        if (gen_q != 32'd0) n_ovw = ovw_q + 32'd1;
        n_gen = (gen_q == 32'hFFFF_FFFF) ? 32'd1 : gen_q + 32'd1;
        if (rdy && seq_new && !stop_q && cmd_q.ctrl_fields_ok) begin
          n_mbok = 1'b1; n_ctrl = 1'b1; n_last_ctrl = cmd_q.seq;
          n_cdog = 1'b1; n_cmark = now_q;
        end else begin
          n_mbok = 1'b0; n_ctrl = 1'b0; n_cdog = 1'b0;
        end
      end
      ACT_STOP, ACT_CLEAR: begin
        r_id = cmd_q.req_id;
        if (!rdy) begin
          n_rec = 1'b1; r_kind = RkNack; r_code = NackNotReady;
        end else if (hit_q && hit_dup_q) begin
          r_kind = hit_ack_q ? RkAck : RkNack; r_code = hit_code_q;
        end else if (hit_q) begin
          r_kind = RkNack; r_code = NackConflict;
        end else if (!seq_new) begin
          n_rec = 1'b1; r_kind = RkNack; r_code = NackStale;
        end else if (kind_bit && !(n_link == LINK_UP && stop_q)) begin
          n_rec = 1'b1; r_kind = RkNack; r_code = NackClearDenied;
        end else begin
          n_rec = 1'b1; n_ack = 1'b1; r_kind = RkAck; r_code = CodeOk;
          n_stop = !kind_bit; n_ctrl = 1'b0; n_cdog = 1'b0; n_mbok = 1'b0;
        end
      end
      ACT_TICK: begin
        n_now = now_q + 32'd1;
        if (ldog_q && (n_now - lmark_q) >= {16'd0, cfg_i.link_timeout}) begin
          n_ldog = 1'b0; n_cdog = 1'b0; n_link = LINK_LOST; n_peer = 1'b0;
          n_seqk = 1'b0; n_ctrl = 1'b0; n_mbok = 1'b0;
        end else if (cdog_q && (n_now - cmark_q) >= {16'd0, cfg_i.ctrl_timeout}) begin
          n_cdog = 1'b0; n_ctrl = 1'b0; n_mbok = 1'b0;
        end
      end
      default: ;
    endcase
  end

  wire logic exec = (st_q == BK_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= LINK_WAIT;
      {peer_q, seqk_q, stop_q, ctrl_q, mbok_q, ldog_q, cdog_q} <= '0;
      peer_id_q <= '0; last_rx_q <= '0; last_ctrl_q <= '0; gap_q <= '0;
      gen_q <= '0; ovw_q <= '0; now_q <= '0; lmark_q <= '0; cmark_q <= '0;
      used_q <= '0; next_q <= '0; scan_q <= '0;
      hit_q <= 1'b0; hit_dup_q <= 1'b0; hit_ack_q <= 1'b0; hit_code_q <= '0;
      full_q <= 1'b0;
    end else begin
      if (cmd_take_o) begin
        scan_q <= '0; hit_q <= 1'b0;
      end
      if (st_q == BK_SCAN) begin
        if (!hit_q && entry_match) begin
          hit_q <= 1'b1;
          hit_dup_q <= (e_crc_q[scan_q] == cmd_q.crc);
          hit_ack_q <= e_ack_q[scan_q];
          hit_code_q <= e_code_q[scan_q];
        end
        if (!last_scan) scan_q <= scan_q + ReplayIdxW'(1);
      end
      if (exec) begin
        link_q <= n_link; peer_q <= n_peer; seqk_q <= n_seqk; stop_q <= n_stop;
        ctrl_q <= n_ctrl; mbok_q <= n_mbok; ldog_q <= n_ldog; cdog_q <= n_cdog;
        peer_id_q <= n_peer_id; last_rx_q <= n_last_rx; last_ctrl_q <= n_last_ctrl;
        gap_q <= n_gap; gen_q <= n_gen; ovw_q <= n_ovw; now_q <= n_now;
        lmark_q <= n_lmark; cmark_q <= n_cmark;
        if (n_clear) begin
          used_q <= '0; next_q <= '0;
        end else if (n_rec) begin
          used_q[next_q] <= 1'b1;
          next_q <= (32'(next_q) == ReplayDepth - 1) ? '0 : next_q + ReplayIdxW'(1);
        end
      end
      if (st_q == BK_OUT && (!full_q || pop_i)) full_q <= 1'b1;
      else if (full_q && pop_i) full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && n_rec && !n_clear) begin
      e_kind_q[next_q] <= kind_bit;
      e_id_q[next_q] <= cmd_q.req_id;
      e_crc_q[next_q] <= cmd_q.crc;
      e_ack_q[next_q] <= n_ack;
      e_code_q[next_q] <= r_code;
    end
  end

  // The result waits in a staging register until the output register is free.
  result_t stage_q;
  always_ff @(posedge clk_i) begin
    if (exec) begin
      stage_q.reply_kind <= r_kind;
      stage_q.reply_code <= r_code;
      stage_q.echo_sequence <= r_seq;
      stage_q.echo_id <= r_id;
      stage_q.session_state <= n_link;
      stage_q.remote_stop <= n_stop;
      stage_q.ctrl_valid <= n_ctrl;
      stage_q.last_ctrl_seq <= n_last_ctrl;
      stage_q.gap_total <= n_gap;
      stage_q.mbox_gen <= n_gen;
      stage_q.mbox_valid <= n_mbok;
      stage_q.mbox_overwrites <= n_ovw;
    end
    if (st_q == BK_OUT && (!full_q || pop_i)) out_q <= stage_q;
  end

  `LSS_ASSERT_IMP(a_take_idle, cmd_take_o, st_q == BK_IDLE)
  `LSS_ASSERT_NEXT(a_out_fill, st_q == BK_OUT && !full_q, full_q)
  `LSS_ASSERT_IMP(a_link_peer, link_q == LINK_UP, peer_q)
  `LSS_ASSERT_IMP(a_ctrl_dog, cdog_q, ctrl_q)
endmodule
`default_nettype wire
